@@ sv/kli_pkg.sv @@
package kli_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_EVAL   = 2'd2;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_FEW   = 2'd2;
    localparam logic [1:0] STS_ZSPAN = 2'd3;

    // scalar lane: 33-bit difference times 17-bit offset
    localparam int SPROD_W = 50;
    // color lane: 9-bit difference times 17-bit offset
    localparam int CPROD_W = 26;

    typedef struct packed {
        logic [15:0] marker;
        logic [31:0] scalar;
        logic [31:0] color;   // alpha, blue, green, red from msb down
    } kli_entry_t;

endpackage

@@ sv/keyframe_linear_interpolator.sv @@
// keyframe table with piecewise linear evaluation. one command per transfer, one
// result per command. clear and append go straight to the output register;
// append on a full table is dropped with status 1. evaluate scans the marker
// table through the memory's single read port, one frame at a time (up to
// MAX_KEYFRAMES-1 frames), reads the two segment frames, multiplies, and then
// runs five 50/26-bit restoring dividers in parallel, one quotient bit per
// cycle; the 50-step scalar divide is the longest and sets when an evaluate
// ends. results are saturated and held in an output register, so a new command
// is taken while the last result waits for m_ready. status 2 flags fewer than
// two frames and status 3 a zero span; table contents are undefined until
// appended.
module keyframe_linear_interpolator #(
    parameter int MAX_KEYFRAMES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [15:0] s_position,
    input  logic signed [31:0] s_scalar_value,
    input  logic [7:0]  s_red_in,
    input  logic [7:0]  s_green_in,
    input  logic [7:0]  s_blue_in,
    input  logic [7:0]  s_alpha_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_scalar_out,
    output logic [7:0]  m_red_out,
    output logic [7:0]  m_green_out,
    output logic [7:0]  m_blue_out,
    output logic [7:0]  m_alpha_out,
    output logic [1:0]  m_status
);
    import kli_pkg::*;

    localparam int AW = $clog2(MAX_KEYFRAMES);
    localparam int CW = $clog2(MAX_KEYFRAMES + 1);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SCAN_RD  = 4'd1;
    localparam logic [3:0] ST_SCAN_CK  = 4'd2;
    localparam logic [3:0] ST_RD_LO    = 4'd3;
    localparam logic [3:0] ST_RD_HI    = 4'd4;
    localparam logic [3:0] ST_SEG      = 4'd5;
    localparam logic [3:0] ST_MUL      = 4'd6;
    localparam logic [3:0] ST_DIV_GO   = 4'd7;
    localparam logic [3:0] ST_DIV_WAIT = 4'd8;
    localparam logic [3:0] ST_FIN      = 4'd9;
    localparam logic [3:0] ST_OUT      = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] fc_reg, fc_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] hi_reg, hi_next;

    logic [15:0]   pos_reg;

    // memory port
    logic          mem_we;
    logic [AW-1:0] mem_raddr;
    kli_entry_t    mem_wdata, mem_rdata;

    // segment and arithmetic pipeline
    kli_entry_t           lo_reg;
    logic signed [16:0]   span_reg, off_reg;
    logic signed [32:0]   sdiff_reg;
    logic signed [8:0]    cdiff_reg [4];
    logic signed [SPROD_W-1:0] sprod_reg;
    logic signed [CPROD_W-1:0] cprod_reg [4];

    // result holding
    logic signed [31:0] res_scalar_reg;
    logic [7:0]         res_color_reg [4];
    logic [1:0]         res_status_reg;

    logic               m_valid_reg;
    logic               out_free;
    logic               div_go;
    logic [15:0]        den_mag;
    logic               qneg_s;
    logic               qneg_c [4];
    logic [SPROD_W-1:0] snum, squot;
    logic [CPROD_W-1:0] cnum [4];
    logic [CPROD_W-1:0] cquot [4];
    logic               sbusy;
    logic [3:0]         cbusy;

    logic               s_fire;
    logic signed [50:0] qs, ssum;
    logic signed [26:0] qc [4];
    logic signed [26:0] csum [4];

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign div_go   = (state_reg == ST_DIV_GO);

    // table memory
    assign mem_we    = s_fire && (s_command == CMD_APPEND)
                       && (fc_reg < CW'(MAX_KEYFRAMES));
    assign mem_wdata = '{marker: s_position,
                         scalar: s_scalar_value,
                         color: {s_alpha_in, s_blue_in, s_green_in, s_red_in}};

    always_comb begin
        case (state_reg)
            ST_SCAN_RD: mem_raddr = idx_reg;
            ST_RD_LO:   mem_raddr = hi_reg - AW'(1);
            default:    mem_raddr = hi_reg;
        endcase
    end

    kli_mem #(.DEPTH(MAX_KEYFRAMES), .AW(AW)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (fc_reg[AW-1:0]),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        fc_next    = fc_reg;
        idx_next   = idx_reg;
        hi_next    = hi_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_OUT;
                    case (s_command)
                        CMD_CLEAR: fc_next = '0;
                        CMD_APPEND: begin
                            if (fc_reg < CW'(MAX_KEYFRAMES)) begin
                                fc_next = fc_reg + CW'(1);
                            end
                        end
                        CMD_EVAL: begin
                            if (fc_reg >= CW'(2)) begin
                                idx_next   = '0;
                                state_next = ST_SCAN_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN_RD: state_next = ST_SCAN_CK;
            ST_SCAN_CK: begin
                // first marker above the position, last frame as fallback
                if (mem_rdata.marker > pos_reg) begin
                    hi_next    = (idx_reg == '0) ? AW'(1) : idx_reg;
                    state_next = ST_RD_LO;
                end else if (CW'(idx_reg) + CW'(1) == fc_reg - CW'(1)) begin
                    hi_next    = idx_reg + AW'(1);
                    state_next = ST_RD_LO;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_RD_LO: state_next = ST_RD_HI;
            ST_RD_HI: state_next = ST_SEG;
            ST_SEG: begin
                if (mem_rdata.marker == lo_reg.marker) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_DIV_GO;
            ST_DIV_GO: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (!sbusy && (cbusy == '0)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // divider operands: magnitudes, sign restored afterwards
    assign den_mag = span_reg[16] ? 16'(-span_reg) : span_reg[15:0];
    assign snum    = sprod_reg[SPROD_W-1] ? SPROD_W'(-sprod_reg) : SPROD_W'(sprod_reg);
    assign qneg_s  = sprod_reg[SPROD_W-1] ^ span_reg[16];

    kli_div #(.NW(SPROD_W)) u_sdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_go),
        .num     (snum),
        .den     (den_mag),
        .quot    (squot),
        .busy    (sbusy)
    );

    for (genvar c = 0; c < 4; c++) begin : g_chan
        assign cnum[c]   = cprod_reg[c][CPROD_W-1] ? CPROD_W'(-cprod_reg[c])
                                                   : CPROD_W'(cprod_reg[c]);
        assign qneg_c[c] = cprod_reg[c][CPROD_W-1] ^ span_reg[16];

        kli_div #(.NW(CPROD_W)) u_cdiv (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (div_go),
            .num     (cnum[c]),
            .den     (den_mag),
            .quot    (cquot[c]),
            .busy    (cbusy[c])
        );

        // truncating quotient plus low frame value
        assign qc[c]   = qneg_c[c] ? -$signed({1'b0, cquot[c]}) : $signed({1'b0, cquot[c]});
        assign csum[c] = $signed({19'd0, lo_reg.color[8*c +: 8]}) + qc[c];
    end

    assign qs   = qneg_s ? -$signed({1'b0, squot}) : $signed({1'b0, squot});
    assign ssum = $signed({{19{lo_reg.scalar[31]}}, lo_reg.scalar}) + qs;

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pos_reg        <= s_position;
            res_scalar_reg <= '0;
            for (int c = 0; c < 4; c++) begin
                res_color_reg[c] <= '0;
            end
            case (s_command)
                CMD_APPEND: res_status_reg <= (fc_reg < CW'(MAX_KEYFRAMES)) ? STS_OK
                                                                           : STS_FULL;
                CMD_EVAL:   res_status_reg <= (fc_reg >= CW'(2)) ? STS_OK : STS_FEW;
                default:    res_status_reg <= STS_OK;
            endcase
        end
        if (state_reg == ST_RD_HI) begin
            lo_reg <= mem_rdata;
        end
        if (state_reg == ST_SEG) begin
            span_reg  <= $signed({1'b0, mem_rdata.marker}) - $signed({1'b0, lo_reg.marker});
            off_reg   <= $signed({1'b0, pos_reg}) - $signed({1'b0, lo_reg.marker});
            sdiff_reg <= $signed({mem_rdata.scalar[31], mem_rdata.scalar})
                         - $signed({lo_reg.scalar[31], lo_reg.scalar});
            for (int c = 0; c < 4; c++) begin
                cdiff_reg[c] <= $signed({1'b0, mem_rdata.color[8*c +: 8]})
                                - $signed({1'b0, lo_reg.color[8*c +: 8]});
            end
            if (mem_rdata.marker == lo_reg.marker) begin
                res_status_reg <= STS_ZSPAN;
            end
        end
        if (state_reg == ST_MUL) begin
            sprod_reg <= SPROD_W'(sdiff_reg * off_reg);
            for (int c = 0; c < 4; c++) begin
                cprod_reg[c] <= CPROD_W'(cdiff_reg[c] * off_reg);
            end
        end
        if (state_reg == ST_FIN) begin
            if (ssum > 51'sd2147483647) begin
                res_scalar_reg <= 32'sh7FFFFFFF;
            end else if (ssum < -51'sd2147483648) begin
                res_scalar_reg <= 32'sh80000000;
            end else begin
                res_scalar_reg <= ssum[31:0];
            end
            for (int c = 0; c < 4; c++) begin
                if (csum[c] < 27'sd0) begin
                    res_color_reg[c] <= 8'd0;
                end else if (csum[c] > 27'sd255) begin
                    res_color_reg[c] <= 8'd255;
                end else begin
                    res_color_reg[c] <= csum[c][7:0];
                end
            end
        end
        if (state_reg == ST_OUT && out_free) begin
            m_scalar_out <= res_scalar_reg;
            m_red_out    <= res_color_reg[0];
            m_green_out  <= res_color_reg[1];
            m_blue_out   <= res_color_reg[2];
            m_alpha_out  <= res_color_reg[3];
            m_status     <= res_status_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fc_reg      <= '0;
            idx_reg     <= '0;
            hi_reg      <= AW'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fc_reg    <= fc_next;
            idx_reg   <= idx_next;
            hi_reg    <= hi_next;
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ sv/kli_mem.sv @@
module kli_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic               aclk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  kli_pkg::kli_entry_t wdata,
    input  logic [AW-1:0]      raddr,
    output kli_pkg::kli_entry_t rdata
);
    import kli_pkg::*;

    kli_entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/kli_div.sv @@
module kli_div #(
    parameter int NW = 50
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [15:0]   den,
    output logic [NW-1:0] quot,
    output logic          busy
);
    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   q_reg, q_next;
    logic [15:0]     rem_reg, rem_next;
    logic [15:0]     den_reg;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [16:0]     trial;
    logic [16:0]     diff;

    // restoring divide, one quotient bit per cycle
    always_comb begin
        trial    = {rem_reg, q_reg[NW-1]};
        diff     = trial - {1'b0, den_reg};
        q_next   = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start) begin
            q_next   = num;
            rem_next = '0;
            cnt_next = CNTW'(NW);
        end else if (cnt_reg != '0) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[15:0];
                q_next   = {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = trial[15:0];
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign quot = q_reg;
    assign busy = (cnt_reg != '0);

endmodule
